/* hdl/pcd_pkg.sv */
// pcd_pkg: shared types and constants for the polyline crossing detector.
// No dependencies; compile first.
package pcd_pkg;

	localparam int CMD_W     = 2;
	localparam int STATUS_W  = 3;
	localparam int FIELD_W   = 16;
	localparam int IDX_OUT_W = 8;
	localparam int CNT_OUT_W = 9;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 2'd0,
		CMD_TOGGLE = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_APPENDED = 3'd0,
		ST_CROSSING = 3'd1,
		ST_TOGGLED  = 3'd2,
		ST_NOEFFECT = 3'd3,
		ST_FULL     = 3'd4,
		ST_CLEARED  = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_SCAN_WAIT,
		S_TOG_RD1,
		S_TOG_RD2,
		S_TOG_EVAL,
		S_TOG_WR,
		S_FINISH
	} state_t;

	// handshake from the segment test unit back to the sequencer
	typedef struct packed {
		logic done;
		logic hit;
	} test_res_t;

endpackage

/* hdl/pcd_item_if.sv */
// pcd_item_if / pcd_result_if: valid/ready channels for command and result words.
// Depends on pcd_pkg.
interface pcd_item_if;
	import pcd_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [CMD_W-1:0]          cmd;
	logic signed [FIELD_W-1:0] start_x;
	logic signed [FIELD_W-1:0] start_y;
	logic signed [FIELD_W-1:0] end_x;
	logic signed [FIELD_W-1:0] end_y;

	modport source (output valid, cmd, start_x, start_y, end_x, end_y, input ready);
	modport sink   (input valid, cmd, start_x, start_y, end_x, end_y, output ready);
endinterface

interface pcd_result_if;
	import pcd_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [IDX_OUT_W-1:0] under_index;
	logic [IDX_OUT_W-1:0] over_index;
	logic [CNT_OUT_W-1:0] segment_count;

	modport source (output valid, status, under_index, over_index, segment_count, input ready);
	modport sink   (input valid, status, under_index, over_index, segment_count, output ready);
endinterface

/* hdl/pcd_seg_test.sv */
// pcd_seg_test: four-orientation segment intersection test on one shared multiplier.
// Depends on pcd_pkg.
module pcd_seg_test #(
	parameter int COORD_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [4*COORD_BITS-1:0] seg_a,
	input  logic [4*COORD_BITS-1:0] seg_b,
	output pcd_pkg::test_res_t      res
);
	import pcd_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;
	localparam logic [3:0] LAST_MUL = 4'd7;
	localparam logic [3:0] DONE_STEP = 4'd9;

	function automatic logic between(input logic signed [CB-1:0] a,
		input logic signed [CB-1:0] q, input logic signed [CB-1:0] b);
		return (q > a && q < b) || (q > b && q < a);
	endfunction

	logic signed [CB-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
	assign ax0 = seg_a[4*CB-1 -: CB];
	assign ay0 = seg_a[3*CB-1 -: CB];
	assign ax1 = seg_a[2*CB-1 -: CB];
	assign ay1 = seg_a[CB-1 -: CB];
	assign bx0 = seg_b[4*CB-1 -: CB];
	assign by0 = seg_b[3*CB-1 -: CB];
	assign bx1 = seg_b[2*CB-1 -: CB];
	assign by1 = seg_b[CB-1 -: CB];

	logic signed [DW-1:0] dax_q, day_q, dbx_q, dby_q;
	logic signed [DW-1:0] ex_q [4];
	logic signed [DW-1:0] ey_q [4];
	logic [3:0]           in_q;
	logic [3:0]           oz_q, on_q;
	logic signed [PW-1:0] prod_q, first_q;
	logic                 busy_q;
	logic [3:0]           step_q;

	logic [1:0]           k;
	logic                 odd;
	logic signed [DW-1:0] mul_x, mul_y;
	logic signed [PW-1:0] prod_d;
	logic [3:0]           acc_j;

	// step: products 0..7 -> orientation k = step/2, even X*Y, odd Z*W
	assign k     = step_q[2:1];
	assign odd   = step_q[0];
	assign mul_x = odd ? (k[1] ? dbx_q : dax_q) : (k[1] ? dby_q : day_q);
	assign mul_y = odd ? ey_q[k] : ex_q[k];
	assign prod_d = PW'(mul_x) * PW'(mul_y);
	assign acc_j = step_q - 4'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 4'd1;
			if (step_q == DONE_STEP)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dax_q <= DW'(ax1) - DW'(ax0);
			day_q <= DW'(ay1) - DW'(ay0);
			dbx_q <= DW'(bx1) - DW'(bx0);
			dby_q <= DW'(by1) - DW'(by0);
			ex_q[0] <= DW'(bx0) - DW'(ax1);
			ey_q[0] <= DW'(by0) - DW'(ay1);
			ex_q[1] <= DW'(bx1) - DW'(ax1);
			ey_q[1] <= DW'(by1) - DW'(ay1);
			ex_q[2] <= DW'(ax0) - DW'(bx1);
			ey_q[2] <= DW'(ay0) - DW'(by1);
			ex_q[3] <= DW'(ax1) - DW'(bx1);
			ey_q[3] <= DW'(ay1) - DW'(by1);
			in_q[0] <= between(ax0, bx0, ax1) && between(ay0, by0, ay1);
			in_q[1] <= between(ax0, bx1, ax1) && between(ay0, by1, ay1);
			in_q[2] <= between(bx0, ax0, bx1) && between(by0, ay0, by1);
			in_q[3] <= between(bx0, ax1, bx1) && between(by0, ay1, by1);
		end else if (busy_q) begin
			if (step_q <= LAST_MUL)
				prod_q <= prod_d;
			if (step_q != 4'd0 && acc_j <= LAST_MUL) begin
				if (!acc_j[0]) begin
					first_q <= prod_q;
				end else begin
					oz_q[acc_j[2:1]] <= (first_q == prod_q);
					on_q[acc_j[2:1]] <= (first_q < prod_q);
				end
			end
		end
	end

	logic ne01, ne23;
	assign ne01 = (oz_q[0] != oz_q[1]) || (!oz_q[0] && on_q[0] != on_q[1]);
	assign ne23 = (oz_q[2] != oz_q[3]) || (!oz_q[2] && on_q[2] != on_q[3]);

	assign res.done = busy_q && (step_q == DONE_STEP);
	assign res.hit  = (ne01 && ne23) || |(oz_q & in_q);

endmodule

/* hdl/polyline_crossing_detector.sv */
// Polyline crossing detector: segment table with under marks, append/toggle/clear.
// Append: writes the new entry, then scans older unmarked entries one at a time through
// the single shared multiplier test unit, skipping marked ones, until the first crossing.
// Toggle moves the under mark across a held pair; clear, full, no-effect just finish.
// Reset (arst_n, async): table empty, pair forgotten, no result pending.
// Table storage is never cleared; entries past the fill count are simply not read.
module polyline_crossing_detector #(
	parameter int MAX_SEGMENTS = 256,
	parameter int COORD_BITS   = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	pcd_item_if.sink       item,
	pcd_result_if.source   result
);
	import pcd_pkg::*;

	localparam int IW    = $clog2(MAX_SEGMENTS);
	localparam int CW    = $clog2(MAX_SEGMENTS + 1);
	localparam int SEG_W = 4 * COORD_BITS;

	// sequencer and table state
	state_t          state_q, state_d;
	logic [CW-1:0]   cnt_q;
	logic [IW-1:0]   scan_idx_q, new_idx_q, tog_idx_q;
	logic [IW-1:0]   pair_first_q, pair_second_q;
	logic            pair_valid_q;
	logic [SEG_W-1:0] new_seg_q;
	status_t         status_q;
	logic [IW-1:0]   under_q, over_q;
	logic            mark_first_q;

	// output register
	logic                 res_valid_q;
	status_t              res_status_q;
	logic [IDX_OUT_W-1:0] res_under_q, res_over_q;
	logic [CNT_OUT_W-1:0] res_count_q;

	// table memories: coordinates and under marks, one read port each
	logic [SEG_W-1:0] coord_mem [MAX_SEGMENTS];
	logic             mark_mem  [MAX_SEGMENTS];
	logic [SEG_W-1:0] rd_seg_q;
	logic             rd_mark_q;

	logic            item_acc, res_load, full, scan_more;
	logic [IW-1:0]   new_idx, rd_addr, mk_addr;
	logic            mk_we, mk_data, seg_we, test_start;
	logic [SEG_W-1:0] seg_in;
	test_res_t       test_res;

	assign item_acc = item.valid && item.ready;
	assign item.ready = (state_q == S_IDLE);
	assign res_load = (state_q == S_FINISH) && (!res_valid_q || result.ready);
	assign full     = (cnt_q == CW'(MAX_SEGMENTS));
	assign new_idx  = cnt_q[IW-1:0];
	// after entry i: go on while i+1 < n-1, with n the old count = cnt_q-1
	assign scan_more = ((CW+1)'(scan_idx_q) + (CW+1)'(3)) < (CW+1)'(cnt_q);

	// coordinates keep their low COORD_BITS, sign-extended when wider
	assign seg_in = {COORD_BITS'(item.start_x), COORD_BITS'(item.start_y),
	                 COORD_BITS'(item.end_x),   COORD_BITS'(item.end_y)};

	pcd_seg_test #(
		.COORD_BITS(COORD_BITS)
	) u_seg_test (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (test_start),
		.seg_a  (rd_seg_q),
		.seg_b  (new_seg_q),
		.res    (test_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// next state, memory ports and test start
	always_comb begin
		state_d    = state_q;
		rd_addr    = scan_idx_q;
		mk_we      = 1'b0;
		mk_addr    = scan_idx_q;
		mk_data    = 1'b0;
		seg_we     = 1'b0;
		test_start = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (item_acc) begin
					unique case (cmd_t'(item.cmd))
						CMD_APPEND: begin
							if (full) begin
								state_d = S_FINISH;
							end else begin
								seg_we  = 1'b1;
								mk_we   = 1'b1;
								mk_addr = new_idx;
								// nothing to scan with fewer than two older entries
								state_d = (cnt_q >= CW'(2)) ? S_SCAN_RD : S_FINISH;
							end
						end
						CMD_TOGGLE: state_d = pair_valid_q ? S_TOG_RD1 : S_FINISH;
						CMD_CLEAR:  state_d = S_FINISH;
						default:    state_d = S_FINISH;
					endcase
				end
			end
			S_SCAN_RD: state_d = S_SCAN_CHK;
			S_SCAN_CHK: begin
				if (rd_mark_q) begin
					state_d = scan_more ? S_SCAN_RD : S_FINISH;
				end else begin
					test_start = 1'b1;
					state_d    = S_SCAN_WAIT;
				end
			end
			S_SCAN_WAIT: begin
				if (test_res.done) begin
					if (test_res.hit) begin
						mk_we   = 1'b1;
						mk_data = 1'b1;
						state_d = S_FINISH;
					end else begin
						state_d = scan_more ? S_SCAN_RD : S_FINISH;
					end
				end
			end
			S_TOG_RD1: begin
				rd_addr = pair_first_q;
				state_d = S_TOG_RD2;
			end
			S_TOG_RD2: begin
				rd_addr = pair_second_q;
				state_d = S_TOG_EVAL;
			end
			S_TOG_EVAL: begin
				// rd_mark_q now holds the newer entry's mark
				if (mark_first_q) begin
					mk_we   = 1'b1;
					mk_addr = pair_first_q;
					state_d = S_TOG_WR;
				end else if (rd_mark_q) begin
					mk_we   = 1'b1;
					mk_addr = pair_second_q;
					state_d = S_TOG_WR;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_TOG_WR: begin
				mk_we   = 1'b1;
				mk_addr = tog_idx_q;
				mk_data = 1'b1;
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (res_load)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (seg_we)
			coord_mem[new_idx] <= seg_in;
		if (mk_we)
			mark_mem[mk_addr] <= mk_data;
		rd_seg_q  <= coord_mem[rd_addr];
		rd_mark_q <= mark_mem[rd_addr];
	end

	// control state: fill count, remembered pair, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q         <= '0;
			pair_first_q  <= '0;
			pair_second_q <= '0;
			pair_valid_q  <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			if (state_q == S_IDLE && item_acc) begin
				if (cmd_t'(item.cmd) == CMD_CLEAR) begin
					cnt_q         <= '0;
					pair_first_q  <= '0;
					pair_second_q <= '0;
					pair_valid_q  <= 1'b0;
				end else if (cmd_t'(item.cmd) == CMD_APPEND && !full) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
			if (state_q == S_SCAN_WAIT && test_res.done && test_res.hit) begin
				pair_first_q  <= scan_idx_q;
				pair_second_q <= new_idx_q;
				pair_valid_q  <= 1'b1;
			end
			if (res_load)
				res_valid_q <= 1'b1;
			else if (result.ready)
				res_valid_q <= 1'b0;
		end
	end

	// working payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (item_acc) begin
					scan_idx_q <= '0;
					new_idx_q  <= new_idx;
					new_seg_q  <= seg_in;
					under_q    <= '0;
					over_q     <= '0;
					unique case (cmd_t'(item.cmd))
						CMD_APPEND: status_q <= full ? ST_FULL : ST_APPENDED;
						CMD_CLEAR:  status_q <= ST_CLEARED;
						CMD_TOGGLE: status_q <= ST_NOEFFECT;
						default:    status_q <= ST_NOEFFECT;
					endcase
				end
			end
			S_SCAN_CHK: begin
				if (rd_mark_q)
					scan_idx_q <= scan_idx_q + IW'(1);
			end
			S_SCAN_WAIT: begin
				if (test_res.done) begin
					if (test_res.hit) begin
						status_q <= ST_CROSSING;
						under_q  <= scan_idx_q;
						over_q   <= new_idx_q;
					end else begin
						scan_idx_q <= scan_idx_q + IW'(1);
					end
				end
			end
			S_TOG_RD2: mark_first_q <= rd_mark_q;
			S_TOG_EVAL: begin
				if (mark_first_q) begin
					status_q  <= ST_TOGGLED;
					under_q   <= pair_second_q;
					over_q    <= pair_first_q;
					tog_idx_q <= pair_second_q;
				end else if (rd_mark_q) begin
					status_q  <= ST_TOGGLED;
					under_q   <= pair_first_q;
					over_q    <= pair_second_q;
					tog_idx_q <= pair_first_q;
				end
			end
			default: ;
		endcase
		if (res_load) begin
			res_status_q <= status_q;
			res_under_q  <= IDX_OUT_W'(under_q);
			res_over_q   <= IDX_OUT_W'(over_q);
			res_count_q  <= CNT_OUT_W'(cnt_q);
		end
	end

	assign result.valid         = res_valid_q;
	assign result.status        = res_status_q;
	assign result.under_index   = res_under_q;
	assign result.over_index    = res_over_q;
	assign result.segment_count = res_count_q;

endmodule

/* hdl/pcd_checker.sv */
// pcd_checker: port-level assertions for polyline_crossing_detector, with its bind.
// Depends on pcd_pkg and the top level.
module pcd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           item_valid,
	input logic                           item_ready,
	input logic                           result_valid,
	input logic                           result_ready,
	input logic [pcd_pkg::STATUS_W-1:0]   status,
	input logic [pcd_pkg::IDX_OUT_W-1:0]  under_index,
	input logic [pcd_pkg::IDX_OUT_W-1:0]  over_index,
	input logic [pcd_pkg::CNT_OUT_W-1:0]  segment_count
);
	import pcd_pkg::*;

	// a stalled result word holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(status) && $stable(under_index)
			&& $stable(over_index) && $stable(segment_count))
		else $error("result word changed while stalled");

	// one word in flight: busy straight after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("ready high in the cycle after an accept");

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == ST_CLEARED |-> segment_count == '0)
		else $error("clear reported a non-empty table");

	a_pair_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == ST_CROSSING || status == ST_TOGGLED)
			|-> under_index != over_index)
		else $error("crossing pair names one segment twice");

endmodule

bind polyline_crossing_detector pcd_checker u_pcd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_valid    (item.valid),
	.item_ready    (item.ready),
	.result_valid  (result.valid),
	.result_ready  (result.ready),
	.status        (result.status),
	.under_index   (result.under_index),
	.over_index    (result.over_index),
	.segment_count (result.segment_count)
);
